// ===== src/text_console_ring_buffer_assert.svh =====
// assertion macros for the text console ring buffer
`ifndef TEXT_CONSOLE_RING_BUFFER_ASSERT_SVH
`define TEXT_CONSOLE_RING_BUFFER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TCRB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("text console check failed");

`define TCRB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console check failed");

`define TCRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console check failed");

`else

`define TCRB_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TCRB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TCRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/tcrb_pkg.sv =====
`timescale 1ns / 1ps

package tcrb_pkg;

    // field widths
    localparam int MODE_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int COL_X_W     = 7;
    localparam int ROW_Y_W     = 5;
    localparam int WORD_W      = 16;
    localparam int COLOR_W     = 4;
    localparam int CFG_INDEX_W = 1;

    // default geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // item modes
    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FG = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BG = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

endpackage

// ===== src/tcrb_ram.sv =====
`timescale 1ns / 1ps

module tcrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tcrb_wrap_add.sv =====
`timescale 1ns / 1ps

// shared unit: add, compare against a limit, subtract the limit on overflow
module tcrb_wrap_add #(
    parameter int W = 11
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_lim,
    output logic [W-1:0] o_res,
    output logic         o_wrap
);

    logic [W:0] sum;
    logic [W:0] diff;

    always_comb begin
        sum    = {1'b0, i_a} + {1'b0, i_b};
        diff   = sum - {1'b0, i_lim};
        o_wrap = (sum >= {1'b0, i_lim});
        o_res  = o_wrap ? diff[W-1:0] : sum[W-1:0];
    end

endmodule

// ===== src/text_console_ring_buffer.sv =====
`timescale 1ns / 1ps
`include "text_console_ring_buffer_assert.svh"

// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------------
// input    | i_in_valid / o_in_ready    | i_mode, i_char_code, i_col_x, i_row_y
// output   | o_out_valid / i_out_ready  | o_cell_word, o_cursor_col, o_cursor_row
// config   | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// after reset the store is swept to zero with o_in_ready low
// put at cursor: S_PUT, S_ROW when the column wraps, S_EMIT; newline: S_PUT per blanked cell, then S_ROW, S_EMIT
// direct put: S_MUL, S_ACC, S_EMIT; display read: S_RADD, the row modulo loop in S_MOD, S_MUL, S_ACC, S_RDATA, S_EMIT
// out-of-range direct put or read goes straight to S_EMIT; mode 3 is taken with no result
// adds, compares and wraps share one unit; the row base uses a constant multiply
// a result waits in S_EMIT only while the previous one is still held, then the next starts
module text_console_ring_buffer #(
    parameter int COLUMNS = tcrb_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcrb_pkg::ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tcrb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [tcrb_pkg::COLOR_W-1:0]       i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [tcrb_pkg::MODE_W-1:0]        i_mode,
    input  logic [tcrb_pkg::CHAR_W-1:0]        i_char_code,
    input  logic [tcrb_pkg::COL_X_W-1:0]       i_col_x,
    input  logic [tcrb_pkg::ROW_Y_W-1:0]       i_row_y,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tcrb_pkg::WORD_W-1:0]        o_cell_word,
    output logic [tcrb_pkg::COL_X_W-1:0]       o_cursor_col,
    output logic [tcrb_pkg::ROW_Y_W-1:0]       o_cursor_row
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    // unit must hold a linear address and cursor row plus any display row
    localparam int SUM_MAX = ROWS + (1 << tcrb_pkg::ROW_Y_W);
    localparam int MAXV    = (DEPTH > SUM_MAX) ? DEPTH : SUM_MAX;
    localparam int UW      = $clog2(MAXV + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PUT   = 4'd2;
    localparam logic [3:0] S_ROW   = 4'd3;
    localparam logic [3:0] S_RADD  = 4'd4;
    localparam logic [3:0] S_MOD   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_RDATA = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]                         r_state, n_state;
    logic [tcrb_pkg::MODE_W-1:0]        r_mode, n_mode;
    logic [tcrb_pkg::CHAR_W-1:0]        r_char, n_char;
    logic [tcrb_pkg::COL_X_W-1:0]       r_x, n_x;
    logic [UW-1:0]                      r_v, n_v;
    logic [UW-1:0]                      r_addr, n_addr;
    logic [CW-1:0]                      r_cur_col, n_cur_col;
    logic [RW-1:0]                      r_cur_row, n_cur_row;
    logic [AW-1:0]                      r_cur_addr, n_cur_addr;
    logic [tcrb_pkg::WORD_W-1:0]        r_word, n_word;
    logic [tcrb_pkg::COLOR_W-1:0]       r_fg, r_bg;
    logic                               r_out_valid, n_out_valid;
    logic [tcrb_pkg::WORD_W-1:0]        r_out_word;
    logic [tcrb_pkg::COL_X_W-1:0]       r_out_col;
    logic [tcrb_pkg::ROW_Y_W-1:0]       r_out_row;

    logic                               out_load;
    logic                               x_ok, y_ok;
    logic [UW-1:0]                      unit_a, unit_b, unit_lim, unit_res;
    logic                               unit_wrap;
    logic                               ram_we;
    logic [AW-1:0]                      ram_addr;
    logic [tcrb_pkg::CHAR_W-1:0]        ram_wdata, ram_rdata, shown_char;

    tcrb_wrap_add #(
        .W(UW)
    ) u_unit (
        .i_a    (unit_a),
        .i_b    (unit_b),
        .i_lim  (unit_lim),
        .o_res  (unit_res),
        .o_wrap (unit_wrap)
    );

    tcrb_ram #(
        .WIDTH(tcrb_pkg::CHAR_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign x_ok = (32'(i_col_x) < 32'(COLUMNS));
    assign y_ok = (32'(i_row_y) < 32'(ROWS));
    assign shown_char = (ram_rdata == '0) ? tcrb_pkg::SPACE_CODE : ram_rdata;

    // operand select for the shared unit
    always_comb begin
        unit_a   = r_addr;
        unit_b   = UW'(1);
        unit_lim = UW'(DEPTH);
        case (r_state)
            S_PUT: begin
                unit_a   = UW'(r_cur_col);
                unit_lim = UW'(COLUMNS);
            end
            S_ROW: begin
                unit_a   = UW'(r_cur_row);
                unit_lim = UW'(ROWS);
            end
            S_RADD: begin
                unit_a   = UW'(r_cur_row);
                unit_b   = r_v;
                unit_lim = UW'(ROWS);
            end
            S_MOD: begin
                unit_a   = r_v;
                unit_b   = '0;
                unit_lim = UW'(ROWS);
            end
            S_ACC: begin
                unit_b   = UW'(r_x);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_char     = r_char;
        n_x        = r_x;
        n_v        = r_v;
        n_addr     = r_addr;
        n_cur_col  = r_cur_col;
        n_cur_row  = r_cur_row;
        n_cur_addr = r_cur_addr;
        n_word     = r_word;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = AW'(r_addr);
        ram_wdata  = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = unit_res;
                if (unit_wrap) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_mode;
                    n_char = i_char_code;
                    n_x    = i_col_x;
                    n_v    = UW'(i_row_y);
                    n_word = '0;
                    case (i_mode)
                        tcrb_pkg::MODE_PUT:    n_state = S_PUT;
                        tcrb_pkg::MODE_DIRECT: n_state = (x_ok && y_ok) ? S_MUL : S_EMIT;
                        tcrb_pkg::MODE_READ:   n_state = x_ok ? S_RADD : S_EMIT;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_PUT: begin
                // a newline keeps writing blanks until the column wraps
                ram_we     = 1'b1;
                ram_addr   = r_cur_addr;
                ram_wdata  = (r_char == tcrb_pkg::NEWLINE_CODE) ? '0 : r_char;
                n_cur_col  = CW'(unit_res);
                n_cur_addr = r_cur_addr + 1'b1;
                if (unit_wrap) begin
                    n_state = S_ROW;
                end else if (r_char != tcrb_pkg::NEWLINE_CODE) begin
                    n_state = S_EMIT;
                end
            end
            S_ROW: begin
                n_cur_row = RW'(unit_res);
                if (unit_wrap) begin
                    n_cur_addr = '0;
                end
                n_state = S_EMIT;
            end
            S_RADD: begin
                n_v     = unit_res;
                n_state = S_MOD;
            end
            S_MOD: begin
                if (unit_wrap) begin
                    n_v = unit_res;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_addr  = UW'(r_v * UW'(COLUMNS));
                n_state = S_ACC;
            end
            S_ACC: begin
                ram_addr  = AW'(unit_res);
                ram_we    = (r_mode == tcrb_pkg::MODE_DIRECT);
                ram_wdata = r_char;
                n_state   = (r_mode == tcrb_pkg::MODE_DIRECT) ? S_EMIT : S_RDATA;
            end
            S_RDATA: begin
                n_word  = {r_bg, r_fg, shown_char};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_cur_addr  <= '0;
            r_out_valid <= 1'b0;
            r_fg        <= tcrb_pkg::FG_RESET;
            r_bg        <= tcrb_pkg::BG_RESET;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_cur_addr  <= n_cur_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcrb_pkg::REG_FG: r_fg <= i_cfg_data;
                    tcrb_pkg::REG_BG: r_bg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_char <= n_char;
        r_x    <= n_x;
        r_v    <= n_v;
        r_word <= n_word;
        if (out_load) begin
            r_out_word <= r_word;
            r_out_col  <= tcrb_pkg::COL_X_W'(r_cur_col);
            r_out_row  <= tcrb_pkg::ROW_Y_W'(r_cur_row);
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_word  = r_out_word;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;

    `TCRB_ASSERT_ALWAYS(a_col_range, i_clk, i_rst_n, 32'(r_cur_col) < 32'(COLUMNS))
    `TCRB_ASSERT_ALWAYS(a_row_range, i_clk, i_rst_n, 32'(r_cur_row) < 32'(ROWS))
    `TCRB_ASSERT_IMPLY(a_mod_done, i_clk, i_rst_n, r_state == S_MUL, 32'(r_v) < 32'(ROWS))
    `TCRB_ASSERT_IMPLY(a_wr_range, i_clk, i_rst_n, ram_we, 32'(ram_addr) < 32'(DEPTH))
    `TCRB_ASSERT_NEXT(a_emit, i_clk, i_rst_n, out_load, o_out_valid && r_state == S_IDLE)

endmodule

// ===== dv/text_console_ring_buffer_checker.sv =====
`timescale 1ns / 1ps

module text_console_ring_buffer_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tcrb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tcrb_pkg::COLOR_W-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [tcrb_pkg::MODE_W-1:0]      i_mode,
    input  logic [tcrb_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tcrb_pkg::COL_X_W-1:0]     i_col_x,
    input  logic [tcrb_pkg::ROW_Y_W-1:0]     i_row_y,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [tcrb_pkg::WORD_W-1:0]      i_cell_word,
    input  logic [tcrb_pkg::COL_X_W-1:0]     i_cursor_col,
    input  logic [tcrb_pkg::ROW_Y_W-1:0]     i_cursor_row,
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_checked
);
    import tcrb_pkg::*;

    localparam int CELLS = COLUMNS_DEF * ROWS_DEF;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [COL_X_W-1:0] col;
        logic [ROW_Y_W-1:0] row;
    } t_console_result;

    logic [CHAR_W-1:0]  shadow_text [CELLS];
    logic [COL_X_W-1:0] cursor_col;
    logic [ROW_Y_W-1:0] cursor_row;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    t_console_result    expected_cells[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic write_at_cursor(input logic [CHAR_W-1:0] byte_val);
        shadow_text[int'(cursor_row) * COLUMNS_DEF + int'(cursor_col)] = byte_val;
        if (int'(cursor_col) == COLUMNS_DEF - 1) begin
            cursor_col = '0;
            if (int'(cursor_row) == ROWS_DEF - 1) begin
                cursor_row = '0;
            end else begin
                cursor_row = cursor_row + 1'b1;
            end
        end else begin
            cursor_col = cursor_col + 1'b1;
        end
    endtask

    // updates the shadow console and queues the word the block should return
    task automatic predict_console_item(
        input logic [MODE_W-1:0]  mode,
        input logic [CHAR_W-1:0]  char_code,
        input logic [COL_X_W-1:0] col_x,
        input logic [ROW_Y_W-1:0] row_y
    );
        logic [WORD_W-1:0] word;
        logic [CHAR_W-1:0] shown;
        int                store_row;
        word = '0;
        case (mode)
            MODE_PUT: begin
                if (char_code == NEWLINE_CODE) begin
                    // blank up to the end of the row, a full row from column 0
                    do begin
                        write_at_cursor('0);
                    end while (cursor_col != '0);
                end else begin
                    write_at_cursor(char_code);
                end
            end
            MODE_DIRECT: begin
                if (int'(col_x) < COLUMNS_DEF && int'(row_y) < ROWS_DEF) begin
                    shadow_text[int'(row_y) * COLUMNS_DEF + int'(col_x)] = char_code;
                end
            end
            MODE_READ: begin
                if (int'(col_x) < COLUMNS_DEF) begin
                    // display rows scroll with the cursor row
                    store_row = (int'(cursor_row) + int'(row_y)) % ROWS_DEF;
                    shown = shadow_text[store_row * COLUMNS_DEF + int'(col_x)];
                    if (shown == '0) begin
                        shown = SPACE_CODE;
                    end
                    word = {bg_color, fg_color, shown};
                end
            end
            default: begin
                return;
            end
        endcase
        expected_cells.push_back('{word, cursor_col, cursor_row});
    endtask

    always @(posedge i_clk) begin : watch
        t_console_result want;
        t_console_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                shadow_text[i] = '0;
            end
            cursor_col = '0;
            cursor_row = '0;
            fg_color   = FG_RESET;
            bg_color   = BG_RESET;
            expected_cells.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FG: fg_color = i_cfg_data;
                    REG_BG: bg_color = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_console_item(i_mode, i_char_code, i_col_x, i_row_y);
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_cell_word, i_cursor_col, i_cursor_row};
                if (expected_cells.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("%0t: result with nothing pending: word %h col %0d row %0d",
                                 $realtime, got.word, got.col, got.row);
                    end
                end else begin
                    want = expected_cells.pop_front();
                    o_checked++;
                    if (want.word !== got.word || want.col !== got.col
                            || want.row !== got.row) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display({"%0t: mismatch word %h/%h col %0d/%0d",
                                      " row %0d/%0d (exp/act)"},
                                     $realtime, want.word, got.word, want.col, got.col,
                                     want.row, got.row);
                        end
                    end
                end
            end
        end
        o_pending = expected_cells.size();
    end

endmodule

// ===== dv/text_console_ring_buffer_tb.sv =====
`timescale 1ns / 1ps

module text_console_ring_buffer_tb;
    import tcrb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 10000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 216;
    localparam int CALM_TAIL    = 150;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]     cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [MODE_W-1:0]      mode;
    logic [CHAR_W-1:0]      char_code;
    logic [COL_X_W-1:0]     col_x;
    logic [ROW_Y_W-1:0]     row_y;
    logic                   out_valid;
    logic                   out_ready;
    logic [WORD_W-1:0]      cell_word;
    logic [COL_X_W-1:0]     cursor_col;
    logic [ROW_Y_W-1:0]     cursor_row;

    int errors;
    int pending;
    int checked;
    int idle_pct;
    int quiet_cycles;
    int put_count;
    int newline_count;
    int direct_count;
    int read_count;
    int unused_count;
    int color_settings;

    text_console_ring_buffer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_mode       (mode),
        .i_char_code  (char_code),
        .i_col_x      (col_x),
        .i_row_y      (row_y),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_cell_word  (cell_word),
        .o_cursor_col (cursor_col),
        .o_cursor_row (cursor_row)
    );

    text_console_ring_buffer_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_mode       (mode),
        .i_char_code  (char_code),
        .i_col_x      (col_x),
        .i_row_y      (row_y),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_cell_word  (cell_word),
        .i_cursor_col (cursor_col),
        .i_cursor_row (cursor_row),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // consumer side stalls in bursts, each started with a chance of idle_pct percent
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_console_item(
        input logic [MODE_W-1:0]  m,
        input logic [CHAR_W-1:0]  ch,
        input logic [COL_X_W-1:0] x,
        input logic [ROW_Y_W-1:0] y
    );
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        char_code <= ch;
        col_x     <= x;
        row_y     <= y;
        case (m)
            MODE_PUT: begin
                put_count++;
                if (ch == NEWLINE_CODE) newline_count++;
            end
            MODE_DIRECT: direct_count++;
            MODE_READ:   read_count++;
            default:     unused_count++;
        endcase
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    // drop valid, drain every pending result, then let in-flight work finish
    task automatic drain_console;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FG;
        cfg_data  <= fg;
        @(negedge i_clk);
        cfg_index <= REG_BG;
        cfg_data  <= bg;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        @(negedge i_clk);
        color_settings++;
    endtask

    task automatic send_random_item;
        int                 pick;
        logic [CHAR_W-1:0]  ch;
        logic [COL_X_W-1:0] x;
        logic [ROW_Y_W-1:0] y;
        pick = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        x    = ($urandom_range(0, 9) == 0) ? COL_X_W'($urandom_range(COLUMNS_DEF, 127))
                                           : COL_X_W'($urandom_range(0, COLUMNS_DEF - 1));
        y    = ($urandom_range(0, 9) == 0) ? ROW_Y_W'($urandom_range(ROWS_DEF, 31))
                                           : ROW_Y_W'($urandom_range(0, ROWS_DEF - 1));
        if (pick < 40) begin
            if ($urandom_range(0, 99) < 18) ch = NEWLINE_CODE;
            send_console_item(MODE_PUT, ch, x, y);
        end else if (pick < 55) begin
            send_console_item(MODE_DIRECT, ch, x, y);
        end else if (pick < 95) begin
            send_console_item(MODE_READ, ch, x, y);
        end else begin
            send_console_item(MODE_UNUSED, ch, x, y);
        end
    endtask

    initial begin
        logic [COLOR_W-1:0] fg_set [PHASES];
        logic [COLOR_W-1:0] bg_set [PHASES];
        int                 idle_choice [3];
        int                 failures;

        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_FG;
        cfg_data  = '0;
        in_valid  = 1'b0;
        mode      = MODE_PUT;
        char_code = '0;
        col_x     = '0;
        row_y     = '0;
        idle_pct  = 0;
        quiet_cycles   = 0;
        put_count      = 0;
        newline_count  = 0;
        direct_count   = 0;
        read_count     = 0;
        unused_count   = 0;
        color_settings = 1;
        idle_choice    = '{0, 15, 40};

        // phase 0 keeps the reset colors
        fg_set = '{FG_RESET, 4'd0, 4'd15, 4'd0, 4'd9};
        bg_set = '{BG_RESET, 4'd0, 4'd15, 4'd15, 4'd6};
        fg_set[3] = COLOR_W'($urandom_range(0, 15));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: edges of the cursor, newline cases, out-of-range cells
        idle_pct = 20;
        send_console_item(MODE_READ,   8'd0,   7'd0,   5'd0);
        send_console_item(MODE_PUT,    8'd65,  7'd0,   5'd0);
        send_console_item(MODE_PUT,    8'd0,   7'd0,   5'd0);
        send_console_item(MODE_PUT,    8'd255, 7'd0,   5'd0);
        send_console_item(MODE_PUT,    NEWLINE_CODE, 7'd0, 5'd0);
        send_console_item(MODE_PUT,    NEWLINE_CODE, 7'd127, 5'd31);
        send_console_item(MODE_DIRECT, 8'd255, 7'd0,   5'd0);
        send_console_item(MODE_DIRECT, 8'd1,   7'd79,  5'd24);
        send_console_item(MODE_DIRECT, 8'd7,   7'd80,  5'd0);
        send_console_item(MODE_DIRECT, 8'd7,   7'd127, 5'd31);
        send_console_item(MODE_DIRECT, 8'd7,   7'd5,   5'd25);
        send_console_item(MODE_DIRECT, NEWLINE_CODE, 7'd3, 5'd3);
        send_console_item(MODE_READ,   8'd0,   7'd0,   5'd0);
        send_console_item(MODE_READ,   8'd0,   7'd0,   5'd23);
        send_console_item(MODE_READ,   8'd0,   7'd79,  5'd22);
        send_console_item(MODE_READ,   8'd0,   7'd80,  5'd0);
        send_console_item(MODE_READ,   8'd255, 7'd127, 5'd31);
        send_console_item(MODE_READ,   8'd0,   7'd3,   5'd31);
        send_console_item(MODE_READ,   8'd0,   7'd3,   5'd1);
        send_console_item(MODE_UNUSED, 8'd255, 7'd127, 5'd31);
        send_console_item(MODE_PUT,    NEWLINE_CODE, 7'd0, 5'd0);
        send_console_item(MODE_READ,   8'd0,   7'd0,   5'd24);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_console();
                set_colors(fg_set[ph], bg_set[ph]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == PHASES - 1 && n >= PHASE_ITEMS - CALM_TAIL) begin
                    idle_pct = 0;
                end else if (n % 40 == 0) begin
                    idle_pct = idle_choice[$urandom_range(0, 2)];
                end
                send_random_item();
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        failures = errors + pending;
        $display("sent %0d puts (%0d newlines), %0d direct puts, %0d reads, %0d unused-mode items",
                 put_count, newline_count, direct_count, read_count, unused_count);
        $display("checked %0d results over %0d color settings, %0d failures",
                 checked, color_settings, failures);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
